### hw/rtl/wctt_pkg.sv
// Shared types, constants and op codes of the wake client tracking table.
package wctt_pkg;

  localparam int MAX_CLIENTS_DEF = 64;
  localparam int KEY_WIDTH_DEF   = 32;
  localparam int CNT_W           = 7;
  localparam int PADDR_W         = 3;

  localparam logic [3:0] OP_REGISTER   = 4'd0;
  localparam logic [3:0] OP_UNREGISTER = 4'd1;
  localparam logic [3:0] OP_SET_NR     = 4'd2;
  localparam logic [3:0] OP_CLR_NR     = 4'd3;
  localparam logic [3:0] OP_SUSPEND    = 4'd4;
  localparam logic [3:0] OP_TOT_BLOCK  = 4'd5;
  localparam logic [3:0] OP_CLI_BLOCK  = 4'd6;
  localparam logic [3:0] OP_CLR_CNT    = 4'd7;
  localparam logic [3:0] OP_READ_SLOT  = 4'd8;

  localparam logic [PADDR_W-1:0] REG_SUSP_TYPE = 3'd0;

  typedef struct packed {
    logic [3:0]  op;
    logic [31:0] client_key;
    logic [3:0]  lock_type;
    logic [5:0]  slot_index;
  } in_req_t;

  typedef struct packed {
    logic        found;
    logic [5:0]  match_slot;
    logic [6:0]  client_count;
    logic [63:0] not_ready_mask;
    logic [31:0] total_blocks;
    logic [31:0] suspend_attempts;
    logic [31:0] slot_blocks;
    logic [31:0] slot_refs;
    logic [31:0] slot_key;
  } out_res_t;

  typedef struct packed {
    logic load;
    logic idx_inc;
    logic rd_idx;
    logic rd_idx1;
    logic rd_slot;
    logic cmp;
    logic exec;
    logic shift_start;
    logic shift_wr;
    logic count_dec;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic keyop;
    logic rd_ok;
    logic idx_end;
    logic match;
    logic remove;
    logic sh_end;
    logic out_busy;
  } sts_t;

endpackage

### hw/rtl/wctt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wctt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/wctt_ctrl.sv
// Sequencer of the wake client tracking table: search, execute, compaction walk, output.
module wctt_ctrl import wctt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_DEC   = 8'b0000_0010,
    S_SRD   = 8'b0000_0100,
    S_SCMP  = 8'b0000_1000,
    S_EXEC  = 8'b0001_0000,
    S_SHCHK = 8'b0010_0000,
    S_SHWR  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.keyop) begin
          state_nxt = S_SRD;
        end else begin
          cmd.rd_slot = sts.rd_ok;
          state_nxt = S_EXEC;
        end
      end
      S_SRD: begin
        if (sts.idx_end) begin
          state_nxt = S_EXEC;
        end else begin
          cmd.rd_idx = 1'b1;
          state_nxt = S_SCMP;
        end
      end
      S_SCMP: begin
        cmd.cmp = 1'b1;
        if (sts.match) begin
          state_nxt = S_EXEC;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt = S_SRD;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.remove) begin
          cmd.shift_start = 1'b1;
          state_nxt = S_SHCHK;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SHCHK: begin
        if (sts.sh_end) begin
          cmd.count_dec = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.rd_idx1 = 1'b1;
          state_nxt = S_SHWR;
        end
      end
      S_SHWR: begin
        cmd.shift_wr = 1'b1;
        cmd.idx_inc = 1'b1;
        state_nxt = S_SHCHK;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.emit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/wctt_dp.sv
// Datapath of the wake client tracking table: entry RAM, counters, mask, result register.
module wctt_dp import wctt_pkg::*; #(
  parameter int MAX_CLIENTS = MAX_CLIENTS_DEF,
  parameter int KEY_WIDTH   = KEY_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  in_req_t  in_data,
  input  logic [3:0] susp_type,
  input  cmd_t     cmd,
  output sts_t     sts,
  input  logic     out_stall,
  output logic     out_valid,
  output out_res_t out_data
);

  localparam int AW = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
  localparam int EW = KEY_WIDTH + 64;

  in_req_t              req_r;
  logic [CNT_W-1:0]     idx_r;
  logic [CNT_W-1:0]     count_r;
  logic                 hit_r;
  logic                 removed_r;
  logic [5:0]           slot_r;
  logic [KEY_WIDTH-1:0] ent_key_r;
  logic [31:0]          ent_blk_r;
  logic [31:0]          ent_ref_r;
  logic [63:0]          mask_r;
  logic [31:0]          total_r;
  logic [31:0]          attempt_r;
  logic [MAX_CLIENTS-1:0] bv_r;
  logic                 out_valid_r;
  out_res_t             out_r;

  logic [KEY_WIDTH-1:0] key_in;
  logic [CNT_W-1:0]     idx_p1;
  logic                 susp;
  logic                 not_full;
  logic                 rd_ok;
  logic                 we;
  logic                 re;
  logic [AW-1:0]        waddr;
  logic [AW-1:0]        raddr;
  logic [EW-1:0]        wdata;
  logic [EW-1:0]        rdata;
  logic [KEY_WIDTH-1:0] r_key;
  logic [31:0]          r_blk;
  logic [31:0]          r_ref;
  logic [31:0]          ref_inc;
  logic [63:0]          low_keep;
  logic [63:0]          slot_bit;

  assign key_in   = KEY_WIDTH'(req_r.client_key);
  assign idx_p1   = idx_r + 7'd1;
  assign susp     = (req_r.lock_type == susp_type);
  assign not_full = (count_r < CNT_W'(MAX_CLIENTS));
  assign rd_ok    = ({1'b0, req_r.slot_index} < count_r);
  assign r_key    = rdata[EW-1:64];
  assign r_blk    = rdata[63:32];
  assign r_ref    = rdata[31:0];
  assign ref_inc  = (ent_ref_r == 32'hFFFF_FFFF) ? ent_ref_r : ent_ref_r + 32'd1;
  assign low_keep = ~({64{1'b1}} << slot_r);
  assign slot_bit = 64'd1 << slot_r;

  assign sts.keyop    = (req_r.op <= OP_CLR_NR) || (req_r.op == OP_CLI_BLOCK);
  assign sts.rd_ok    = (req_r.op == OP_READ_SLOT) && rd_ok;
  assign sts.idx_end  = (idx_r >= count_r);
  assign sts.match    = (r_key == key_in);
  assign sts.remove   = (req_r.op == OP_UNREGISTER) && susp && hit_r && (ent_ref_r == 32'd1);
  assign sts.sh_end   = (idx_p1 >= count_r);
  assign sts.out_busy = out_valid_r && out_stall;

  always_comb begin
    re = cmd.rd_idx || cmd.rd_idx1 || cmd.rd_slot;
    raddr = idx_r[AW-1:0];
    if (cmd.rd_idx1) begin
      raddr = idx_p1[AW-1:0];
    end else if (cmd.rd_slot) begin
      raddr = req_r.slot_index[AW-1:0];
    end
    we = 1'b0;
    waddr = idx_r[AW-1:0];
    wdata = '0;
    if (cmd.exec) begin
      case (req_r.op)
        OP_REGISTER: begin
          if (susp && not_full) begin
            we = 1'b1;
            if (hit_r) begin
              waddr = slot_r[AW-1:0];
              wdata = {key_in, ent_blk_r, ref_inc};
            end else begin
              waddr = count_r[AW-1:0];
              wdata = {key_in, 32'd0, 32'd1};
            end
          end
        end
        OP_UNREGISTER: begin
          if (susp && hit_r && ent_ref_r != 32'd1) begin
            we = 1'b1;
            waddr = slot_r[AW-1:0];
            wdata = {key_in, ent_blk_r, ent_ref_r - 32'd1};
          end
        end
        OP_CLI_BLOCK: begin
          if (susp && hit_r) begin
            we = 1'b1;
            waddr = slot_r[AW-1:0];
            wdata = {key_in, ent_blk_r + 32'd1, ent_ref_r};
          end
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end
    if (cmd.shift_wr) begin
      we = 1'b1;
      waddr = idx_r[AW-1:0];
      wdata = {r_key, r_blk & {32{bv_r[idx_p1[AW-1:0]]}}, r_ref};
    end
  end

  wctt_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_CLIENTS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
      idx_r <= '0;
      hit_r <= 1'b0;
      removed_r <= 1'b0;
      slot_r <= '0;
      ent_key_r <= '0;
      ent_blk_r <= '0;
      ent_ref_r <= '0;
    end
    if (cmd.idx_inc) begin
      idx_r <= idx_p1;
    end
    if (cmd.cmp && sts.match) begin
      hit_r <= 1'b1;
      slot_r <= idx_r[5:0];
      ent_key_r <= r_key;
      ent_blk_r <= r_blk & {32{bv_r[idx_r[AW-1:0]]}};
      ent_ref_r <= r_ref;
    end
    if (cmd.exec) begin
      case (req_r.op)
        OP_REGISTER: begin
          if (susp && not_full && hit_r) begin
            ent_ref_r <= ref_inc;
          end
        end
        OP_UNREGISTER: begin
          if (susp && hit_r) begin
            ent_ref_r <= ent_ref_r - 32'd1;
            removed_r <= (ent_ref_r == 32'd1);
          end
        end
        OP_CLI_BLOCK: begin
          if (susp && hit_r) begin
            ent_blk_r <= ent_blk_r + 32'd1;
          end
        end
        OP_READ_SLOT: begin
          if (rd_ok) begin
            ent_key_r <= r_key;
            ent_blk_r <= r_blk & {32{bv_r[req_r.slot_index[AW-1:0]]}};
            ent_ref_r <= r_ref;
          end
        end
        default: begin
          ent_ref_r <= ent_ref_r;
        end
      endcase
    end
    if (cmd.shift_start) begin
      idx_r <= {1'b0, slot_r};
    end
    if (cmd.emit) begin
      out_r.found <= hit_r;
      out_r.match_slot <= slot_r;
      out_r.client_count <= count_r;
      out_r.not_ready_mask <= mask_r;
      out_r.total_blocks <= total_r;
      out_r.suspend_attempts <= attempt_r;
      out_r.slot_blocks <= ((hit_r && !removed_r) || req_r.op == OP_READ_SLOT) ?
                           ent_blk_r : 32'd0;
      out_r.slot_refs <= ((hit_r && !removed_r) || req_r.op == OP_READ_SLOT) ?
                         ent_ref_r : 32'd0;
      out_r.slot_key <= (req_r.op == OP_READ_SLOT) ? 32'(ent_key_r) : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      mask_r <= '0;
      total_r <= '0;
      attempt_r <= '0;
      bv_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.exec) begin
        case (req_r.op)
          OP_REGISTER: begin
            if (susp && not_full && !hit_r) begin
              count_r <= count_r + 7'd1;
            end
          end
          OP_UNREGISTER: begin
            if (sts.remove) begin
              mask_r <= ((mask_r >> 1) & ~low_keep) | (mask_r & low_keep);
            end
          end
          OP_SET_NR: begin
            if (hit_r) begin
              mask_r <= mask_r | slot_bit;
            end
          end
          OP_CLR_NR: begin
            if (hit_r) begin
              mask_r <= mask_r & ~slot_bit;
            end
          end
          OP_SUSPEND: begin
            if (attempt_r == 32'hFFFF_FFFF) begin
              bv_r <= '0;
              total_r <= '0;
              attempt_r <= 32'd1;
            end else begin
              attempt_r <= attempt_r + 32'd1;
            end
          end
          OP_TOT_BLOCK: begin
            total_r <= total_r + 32'd1;
          end
          OP_CLR_CNT: begin
            bv_r <= '0;
            total_r <= '0;
            attempt_r <= '0;
          end
          default: begin
            count_r <= count_r;
          end
        endcase
      end
      // any entry write carries a live block count
      if (we) begin
        bv_r[waddr] <= 1'b1;
      end
      if (cmd.count_dec) begin
        count_r <= count_r - 7'd1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### hw/rtl/wake_client_tracking_table.sv
// Wake client tracking table: a packed table of suspend-blocking clients keyed by identity,
// one request at a time. A key request walks the occupied slots through the entry RAM,
// reading and then comparing one slot at a time until it finds a match; an unregister that
// removes an entry then runs a compaction walk that moves each later entry down one slot
// through the same single RAM port. A result waits in the output register while the next
// request is taken.
module wake_client_tracking_table import wctt_pkg::*; #(
  parameter int MAX_CLIENTS = MAX_CLIENTS_DEF,
  parameter int KEY_WIDTH   = KEY_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_req_t            in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_res_t           out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [3:0] susp_type_r;
  cmd_t       cmd;
  sts_t       sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      susp_type_r <= '0;
    end else if (psel && penable && pwrite && paddr[2] == REG_SUSP_TYPE[2]) begin
      susp_type_r <= pwdata[3:0];
    end
  end

  assign prdata = (paddr[2] == REG_SUSP_TYPE[2]) ? {28'd0, susp_type_r} : 32'd0;

  wctt_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  wctt_dp #(
    .MAX_CLIENTS(MAX_CLIENTS),
    .KEY_WIDTH  (KEY_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .susp_type(susp_type_r),
    .cmd      (cmd),
    .sts      (sts),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_data (out_data)
  );

endmodule

### test/wake_client_tracking_table_tb.sv
// Testbench for the wake client tracking table: directed and random requests checked against a predictor.
module wake_client_tracking_table_tb;
  import wctt_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_res_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  wake_client_tracking_table dut (.*);

  always #10 clk = ~clk;

  // predictor state
  logic [31:0] tbl_key [64];
  logic [31:0] tbl_blk [64];
  logic [31:0] tbl_ref [64];
  int unsigned tbl_cnt;
  logic [63:0] nr_bits;
  logic [31:0] blk_total;
  logic [31:0] att_total;
  logic [3:0] susp_type;

  out_res_t pending_results[$];
  logic [31:0] known_keys[$];
  int errors = 0;
  int idle_pct = 24;
  int quiet = 0;
  bit done = 0;

  function automatic out_res_t predict_request(in_req_t r);
    out_res_t res;
    bit keyop, susp, removed;
    int hit;
    int unsigned slot;
    logic [63:0] keep;
    res = '0;
    keyop = (r.op <= OP_CLR_NR) || (r.op == OP_CLI_BLOCK);
    susp = (r.lock_type == susp_type);
    hit = -1;
    removed = 0;
    if (keyop)
      for (int i = 0; i < tbl_cnt; i++)
        if (hit < 0 && tbl_key[i] == r.client_key) hit = i;
    slot = (hit >= 0) ? hit : 0;
    case (r.op)
      OP_REGISTER: begin
        if (susp && tbl_cnt < 64) begin
          if (hit >= 0) begin
            if (tbl_ref[slot] != 32'hFFFFFFFF) tbl_ref[slot]++;
          end else begin
            tbl_key[tbl_cnt] = r.client_key;
            tbl_blk[tbl_cnt] = 0;
            tbl_ref[tbl_cnt] = 1;
            tbl_cnt++;
          end
        end
      end
      OP_UNREGISTER: begin
        if (susp && hit >= 0) begin
          tbl_ref[slot]--;
          if (tbl_ref[slot] == 0) begin
            for (int j = slot; j + 1 < tbl_cnt; j++) begin
              tbl_key[j] = tbl_key[j+1];
              tbl_blk[j] = tbl_blk[j+1];
              tbl_ref[j] = tbl_ref[j+1];
            end
            tbl_key[tbl_cnt-1] = 0;
            tbl_blk[tbl_cnt-1] = 0;
            tbl_ref[tbl_cnt-1] = 0;
            keep = ~({64{1'b1}} << slot);
            nr_bits = ((nr_bits >> 1) & ~keep) | (nr_bits & keep);
            tbl_cnt--;
            removed = 1;
          end
        end
      end
      OP_SET_NR: if (hit >= 0) nr_bits[slot] = 1'b1;
      OP_CLR_NR: if (hit >= 0) nr_bits[slot] = 1'b0;
      OP_SUSPEND: begin
        att_total++;
        if (att_total == 0) begin
          for (int i = 0; i < 64; i++) tbl_blk[i] = 0;
          blk_total = 0;
          att_total = 1;
        end
      end
      OP_TOT_BLOCK: blk_total++;
      OP_CLI_BLOCK: if (susp && hit >= 0) tbl_blk[slot]++;
      OP_CLR_CNT: begin
        for (int i = 0; i < 64; i++) tbl_blk[i] = 0;
        blk_total = 0;
        att_total = 0;
      end
      OP_READ_SLOT: begin
        res.slot_blocks = tbl_blk[r.slot_index];
        res.slot_refs = tbl_ref[r.slot_index];
        res.slot_key = tbl_key[r.slot_index];
      end
      default: ;
    endcase
    if (hit >= 0 && !removed) begin
      res.slot_blocks = tbl_blk[slot];
      res.slot_refs = tbl_ref[slot];
    end
    res.found = (hit >= 0);
    res.match_slot = slot[5:0];
    res.client_count = tbl_cnt[6:0];
    res.not_ready_mask = nr_bits;
    res.total_blocks = blk_total;
    res.suspend_attempts = att_total;
    return res;
  endfunction

  // entered at a falling edge; valid stays up between back-to-back requests
  task automatic send_request(in_req_t r);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < idle_pct) @(negedge clk);
    end
    in_data <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_request(r));
    @(negedge clk);
  endtask

  task automatic send_op(logic [3:0] op, logic [31:0] key, logic [3:0] lt, logic [5:0] si);
    in_req_t r;
    r.op = op;
    r.client_key = key;
    r.lock_type = lt;
    r.slot_index = si;
    send_request(r);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic write_susp_type(logic [3:0] v);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= REG_SUSP_TYPE;
    pwdata <= {28'd0, v};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    susp_type = v;
  endtask

  // random key that the table may already hold
  function automatic logic [31:0] pick_key();
    if (known_keys.size() != 0 && $urandom_range(9) < 8)
      return known_keys[$urandom_range(known_keys.size() - 1)];
    return $urandom();
  endfunction

  // slot reads mostly stay within occupied slots; the rest, and all reads of an empty table, use slot 63
  function automatic logic [5:0] pick_slot();
    if (tbl_cnt == 0 || $urandom_range(9) == 0) return 6'd63 - 6'($urandom_range(3) * 0);
    return 6'($urandom_range(tbl_cnt - 1));
  endfunction

  task automatic test_directed();
    send_op(OP_CLR_NR, 32'h0, 4'h0, 6'd63);
    send_op(OP_UNREGISTER, 32'hFFFFFFFF, 4'h0, 6'd0);
    send_op(OP_REGISTER, 32'hFFFFFFFF, 4'h0, 6'd0);
    send_op(OP_REGISTER, 32'h0, 4'h0, 6'd0);
    send_op(OP_REGISTER, 32'h0, 4'hF, 6'd0);
    send_op(OP_REGISTER, 32'h0, 4'h0, 6'd0);
    send_op(OP_SET_NR, 32'h0, 4'hF, 6'd0);
    send_op(OP_SET_NR, 32'hFFFFFFFF, 4'h5, 6'd0);
    send_op(OP_CLI_BLOCK, 32'h0, 4'h0, 6'd0);
    send_op(OP_CLI_BLOCK, 32'h0, 4'hA, 6'd0);
    send_op(OP_TOT_BLOCK, 32'h0, 4'h0, 6'd0);
    send_op(OP_SUSPEND, 32'h0, 4'h0, 6'd0);
    send_op(OP_UNREGISTER, 32'hFFFFFFFF, 4'h0, 6'd0);
    send_op(OP_READ_SLOT, 32'h0, 4'h0, 6'd0);
    send_op(OP_CLR_NR, 32'h0, 4'h0, 6'd0);
    send_op(OP_CLR_CNT, 32'h0, 4'h0, 6'd0);
    send_op(4'd9, 32'h0, 4'h0, 6'd0);
    send_op(4'd15, 32'hFFFFFFFF, 4'hF, 6'd63);
    send_op(OP_UNREGISTER, 32'h0, 4'h0, 6'd0);
    send_op(OP_UNREGISTER, 32'h0, 4'h0, 6'd0);
  endtask

  task automatic test_full_table();
    for (int i = 0; i < 66; i++) send_op(OP_REGISTER, 32'h1000 + i, susp_type, 6'd0);
    send_op(OP_REGISTER, 32'h1000, susp_type, 6'd0);
    send_op(OP_SET_NR, 32'h103F, 4'h0, 6'd0);
    send_op(OP_READ_SLOT, 32'h0, 4'h0, 6'd63);
    send_op(OP_UNREGISTER, 32'h1000, susp_type, 6'd0);
    for (int i = 1; i < 64; i++) send_op(OP_UNREGISTER, 32'h1000 + i, susp_type, 6'd0);
  endtask

  task automatic test_random(int n);
    in_req_t r;
    for (int k = 0; k < n; k++) begin
      idle_pct = (k >= n / 3 && k < n / 2) ? 0 : 24;
      r.op = ($urandom_range(19) == 0) ? 4'($urandom_range(15)) :
             4'($urandom_range(OP_READ_SLOT));
      if ($urandom_range(5) == 0 && r.op == OP_UNREGISTER) r.op = OP_REGISTER;
      r.client_key = pick_key();
      r.lock_type = ($urandom_range(4) == 0) ? 4'($urandom()) : susp_type;
      r.slot_index = pick_slot();
      if (r.op == OP_REGISTER && known_keys.size() < 40) known_keys.push_back(r.client_key);
      send_request(r);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall))) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_res_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected request result %h", $time, out_data);
        errors++;
      end else begin
        exp_res = pending_results.pop_front();
        if (exp_res != out_data) begin
          $display("%0t mismatch expected %h actual %h", $time, exp_res, out_data);
          errors++;
        end
      end
    end
  end

  always @(negedge clk)
    out_stall <= (idle_pct != 0) && ($urandom_range(99) < 24);

  initial begin
    for (int i = 0; i < 64; i++) begin
      tbl_key[i] = 0;
      tbl_blk[i] = 0;
      tbl_ref[i] = 0;
    end
    tbl_cnt = 0;
    nr_bits = 0;
    blk_total = 0;
    att_total = 0;
    susp_type = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    write_susp_type(4'hF);
    test_full_table();
    test_random(250);
    write_susp_type(4'h5);
    test_random(250);
    write_susp_type(4'h0);
    test_random(250);
    drain();
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

### files.f
hw/rtl/wctt_pkg.sv
hw/rtl/wctt_ram.sv
hw/rtl/wctt_ctrl.sv
hw/rtl/wctt_dp.sv
hw/rtl/wake_client_tracking_table.sv
test/wake_client_tracking_table_tb.sv
